>>> hw/rtl/tsc_pkg.sv
// Shared types and constants for the template score classifier.
// Holds the record layout, field offsets, datapath command/status structs and FSM states.
// No dependencies.
package tsc_pkg;

    localparam int MAX_CLASSIFIERS = 32;
    localparam int PROFILE_POINTS  = 8;
    localparam int RECORD_WORDS    = 17;
    localparam int TABLE_DEPTH     = MAX_CLASSIFIERS * RECORD_WORDS;
    localparam int ADDR_W          = $clog2(TABLE_DEPTH);
    localparam int REC_W           = $clog2(MAX_CLASSIFIERS);
    localparam int COUNT_W         = 6;
    localparam int WORD_IDX_W      = 5;

    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // input beat layout, lowest bit first
    localparam int IN_PROF_LSB     = 0;
    localparam int IN_SYM_LSB      = 128;
    localparam int IN_CPX_LSB      = 144;
    localparam int IN_HOLES_LSB    = 160;
    localparam int IN_RADIAL_LSB   = 168;
    localparam int IN_CONTRAST_LSB = 184;
    localparam int IN_SLOT_LSB     = 200;
    localparam int IN_WSEL_LSB     = 205;
    localparam int IN_WDATA_LSB    = 210;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CLASSIFIER_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FLORAL_CLASS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNKNOWN_CLASS    = 2'd2;

    // record word positions
    localparam int W_WEIGHT_PROF = 8;
    localparam int W_WEIGHT_SYM  = 9;
    localparam int W_WEIGHT_CPX  = 10;
    localparam int W_WEIGHT_HOLE = 11;
    localparam int W_TH_RADIAL   = 12;
    localparam int W_TH_SYM      = 13;
    localparam int W_TH_CONTRAST = 14;
    localparam int W_REQ_HOLES   = 15;
    localparam int W_CLASS       = 16;

    // x/10 = (x * RECIP) >> 35, x/5 = (x * RECIP) >> 34, exact for 32-bit x
    localparam logic [31:0] DIV_RECIP = 32'hCCCC_CCCD;

    localparam logic signed [31:0] ONE_Q24     = 32'sh0100_0000;
    localparam logic signed [21:0] CONF_MAX    = 22'sd32768;
    localparam logic signed [21:0] CONF_ACCEPT = 22'sd16384;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_WRITE,
        OP_BEST_INIT,
        OP_FETCH,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_PROF_MUL,
        OP_PROF_ADD,
        OP_SYM_ADD,
        OP_CPX_ADD,
        OP_HOLE,
        OP_DIV_FIN,
        OP_RADIAL,
        OP_SYM_TH,
        OP_CONTRAST,
        OP_CONF,
        OP_SELECT,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t                  op;
        logic [REC_W-1:0]        rec;
        logic [WORD_IDX_W-1:0]   word;
    } dp_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] rec_count;
        logic               hole_mismatch;
        logic               contrast_miss;
        logic               sqrt_last;
        logic               out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRITE,
        S_INIT,
        S_FETCH,
        S_SQ,
        S_SQRT_INIT,
        S_SQRT,
        S_PROF_MUL,
        S_PROF_ADD,
        S_SYM_ADD,
        S_CPX_ADD,
        S_HOLE,
        S_HOLE_DIV,
        S_RADIAL,
        S_SYM_TH,
        S_CONTRAST,
        S_CON_DIV,
        S_CONF,
        S_SELECT,
        S_OUT
    } ctl_state_t;

    function automatic logic [ADDR_W-1:0] rec_addr(input logic [REC_W-1:0] rec,
                                                   input logic [WORD_IDX_W-1:0] word);
        return ADDR_W'(rec) * ADDR_W'(RECORD_WORDS) + ADDR_W'(word);
    endfunction

endpackage

>>> hw/rtl/tsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 544
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tsc_ctl.sv
// Controller for the template score classifier: walks records and sequences the datapath.
// Depends on tsc_pkg.
module tsc_ctl import tsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tuser,
    output logic       s_axis_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctl_state_t            state_reg, state_next;
    logic [COUNT_W-1:0]    rec_reg, rec_next;
    logic [WORD_IDX_W-1:0] word_reg, word_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rec_reg   <= '0;
            word_reg  <= '0;
        end else begin
            state_reg <= state_next;
            rec_reg   <= rec_next;
            word_reg  <= word_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        rec_next      = rec_reg;
        word_next     = word_reg;
        cmd.op        = OP_NOP;
        cmd.rec       = rec_reg[REC_W-1:0];
        cmd.word      = word_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.op     = OP_LATCH;
                    state_next = s_axis_tuser ? S_INIT : S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.op     = OP_WRITE;
                state_next = S_IDLE;
            end
            S_INIT: begin
                cmd.op     = OP_BEST_INIT;
                rec_next   = '0;
                word_next  = '0;
                state_next = (status.rec_count == '0) ? S_OUT : S_FETCH;
            end
            S_FETCH: begin
                // a final fetch step with no read lets the last word land from the RAM
                cmd.op = OP_FETCH;
                if (word_reg == WORD_IDX_W'(RECORD_WORDS)) begin
                    word_next  = '0;
                    state_next = S_SQ;
                end else begin
                    word_next = word_reg + 1'b1;
                end
            end
            S_SQ: begin
                cmd.op = OP_SQ;
                if (word_reg == WORD_IDX_W'(PROFILE_POINTS)) begin
                    word_next  = '0;
                    state_next = S_SQRT_INIT;
                end else begin
                    word_next = word_reg + 1'b1;
                end
            end
            S_SQRT_INIT: begin
                cmd.op     = OP_SQRT_INIT;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op = OP_SQRT_STEP;
                if (status.sqrt_last) begin
                    state_next = S_PROF_MUL;
                end
            end
            S_PROF_MUL: begin
                cmd.op     = OP_PROF_MUL;
                state_next = S_PROF_ADD;
            end
            S_PROF_ADD: begin
                cmd.op     = OP_PROF_ADD;
                state_next = S_SYM_ADD;
            end
            S_SYM_ADD: begin
                cmd.op     = OP_SYM_ADD;
                state_next = S_CPX_ADD;
            end
            S_CPX_ADD: begin
                cmd.op     = OP_CPX_ADD;
                state_next = S_HOLE;
            end
            S_HOLE: begin
                cmd.op     = OP_HOLE;
                state_next = status.hole_mismatch ? S_HOLE_DIV : S_RADIAL;
            end
            S_HOLE_DIV: begin
                cmd.op     = OP_DIV_FIN;
                state_next = S_RADIAL;
            end
            S_RADIAL: begin
                cmd.op     = OP_RADIAL;
                state_next = S_SYM_TH;
            end
            S_SYM_TH: begin
                cmd.op     = OP_SYM_TH;
                state_next = S_CONTRAST;
            end
            S_CONTRAST: begin
                cmd.op     = OP_CONTRAST;
                state_next = status.contrast_miss ? S_CON_DIV : S_CONF;
            end
            S_CON_DIV: begin
                cmd.op     = OP_DIV_FIN;
                state_next = S_CONF;
            end
            S_CONF: begin
                cmd.op     = OP_CONF;
                state_next = S_SELECT;
            end
            S_SELECT: begin
                cmd.op    = OP_SELECT;
                rec_next  = rec_reg + 1'b1;
                word_next = '0;
                if (rec_reg + 1'b1 == status.rec_count) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_OUT: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/tsc_dp.sv
// Datapath for the template score classifier: record table, scoring arithmetic,
// best-match selection, configuration registers and the output register.
// Depends on tsc_pkg and tsc_ram.
module tsc_dp import tsc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
    localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] half(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = 33'(v) + {32'b0, v[31]};
        return t[32:1];
    endfunction

    // latched item
    logic [127:0]        prof_reg;
    logic signed [15:0]  sym_reg, cpx_reg, radial_reg, contrast_reg;
    logic [7:0]          holes_reg;
    logic [4:0]          slot_reg, wsel_reg;
    logic [15:0]         wdata_reg;

    // configuration
    logic [COUNT_W-1:0]  count_reg;
    logic [7:0]          floral_reg, unknown_reg;

    // record fetch
    logic [15:0]           rdata;
    logic                  rd_pend_reg;
    logic [WORD_IDX_W-1:0] rd_idx_reg;
    logic [15:0]           words_reg [RECORD_WORDS];

    // profile match
    logic [31:0]  sq_reg;
    logic         sq_valid_reg;
    logic [34:0]  sum_reg;
    logic [51:0]  rem_reg;
    logic [51:0]  root_reg;
    logic [50:0]  bit_reg;

    // score
    logic signed [40:0] prod_reg;
    logic signed [31:0] score_reg;
    logic [63:0]        div_prod_reg;
    logic               div_neg_reg, div_ten_reg;
    logic signed [21:0] cur_conf_reg;
    logic [7:0]         cur_class_reg;
    logic signed [21:0] best_conf_reg;
    logic [7:0]         best_class_reg;
    logic signed [31:0] best_score_reg;

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    // combinational helpers
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic signed [15:0]  prof_pt, w_pt;
    logic signed [16:0]  diff;
    logic signed [33:0]  diff_sq;
    logic [51:0]         trial;
    logic signed [27:0]  ps_raw;
    logic [24:0]         pscore;
    logic signed [40:0]  prof_q, term_q;
    logic [31:0]         abs_score;
    logic [31:0]         div_q;
    logic signed [32:0]  conf_raw;
    logic signed [21:0]  conf_cap;
    logic signed [15:0]  w_req, w_th_con;
    logic                hole_mismatch, contrast_miss, better, out_free;
    logic [COUNT_W-1:0]  rec_count;

    assign ram_we    = (cmd.op == OP_WRITE) && (wsel_reg < WORD_IDX_W'(RECORD_WORDS));
    assign ram_waddr = rec_addr(slot_reg[REC_W-1:0], wsel_reg);
    assign ram_re    = (cmd.op == OP_FETCH) && (cmd.word < WORD_IDX_W'(RECORD_WORDS));
    assign ram_raddr = rec_addr(cmd.rec, cmd.word);

    tsc_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wdata_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign prof_pt = prof_reg[cmd.word[2:0]*16 +: 16];
    assign w_pt    = words_reg[cmd.word];
    assign diff    = 17'(prof_pt) - 17'(w_pt);
    assign diff_sq = diff * diff;

    assign trial  = root_reg + {1'b0, bit_reg};
    assign ps_raw = 28'(ONE_Q24) - $signed({1'b0, root_reg[26:0]});
    assign pscore = ps_raw[27] ? 25'd0 : ps_raw[24:0];

    // truncate toward zero
    assign prof_q = (prod_reg + (prod_reg[40] ? 41'sd4095 : 41'sd0)) >>> 12;
    assign term_q = (prod_reg + (prod_reg[40] ? 41'sd3 : 41'sd0)) >>> 2;

    assign abs_score = score_reg[31] ? (~score_reg + 32'd1) : score_reg;
    assign div_q     = div_ten_reg ? 32'(div_prod_reg >> 35) : 32'(div_prod_reg >> 34);

    assign conf_raw = (33'(score_reg) + (score_reg[31] ? 33'sd2047 : 33'sd0)) >>> 11;
    assign conf_cap = (22'(conf_raw) > CONF_MAX) ? CONF_MAX : 22'(conf_raw);

    assign w_req         = words_reg[W_REQ_HOLES];
    assign w_th_con      = words_reg[W_TH_CONTRAST];
    assign hole_mismatch = !w_req[15] && ({8'b0, holes_reg} != w_req);
    assign contrast_miss = (w_th_con > 16'sd0) && (contrast_reg > w_th_con);

    always_comb begin
        better = 1'b0;
        if (cur_conf_reg > best_conf_reg) begin
            better = 1'b1;
        end else if (cur_conf_reg == best_conf_reg && best_conf_reg > 22'sd0) begin
            if (best_class_reg == floral_reg && cur_class_reg != floral_reg) begin
                better = 1'b1;
            end else if (cur_class_reg != floral_reg && cur_class_reg > best_class_reg) begin
                better = 1'b1;
            end
        end
    end

    assign rec_count = (count_reg > COUNT_W'(MAX_CLASSIFIERS)) ?
                       COUNT_W'(MAX_CLASSIFIERS) : count_reg;
    assign out_free  = !m_valid_reg || m_axis_tready;

    assign status.rec_count     = rec_count;
    assign status.hole_mismatch = hole_mismatch;
    assign status.contrast_miss = contrast_miss;
    assign status.sqrt_last     = bit_reg[0];
    assign status.out_free      = out_free;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            floral_reg   <= 8'd1;
            unknown_reg  <= 8'd0;
            rd_pend_reg  <= 1'b0;
            sq_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CLASSIFIER_COUNT: count_reg   <= cfg_wdata[COUNT_W-1:0];
                    REG_FLORAL_CLASS:     floral_reg  <= cfg_wdata;
                    REG_UNKNOWN_CLASS:    unknown_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            rd_pend_reg <= ram_re;
            if (cmd.op == OP_FETCH) begin
                sq_valid_reg <= 1'b0;
            end else if (cmd.op == OP_SQ) begin
                sq_valid_reg <= (cmd.word < WORD_IDX_W'(PROFILE_POINTS));
            end
            if (cmd.op == OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LATCH) begin
            prof_reg     <= s_axis_tdata[IN_PROF_LSB +: 128];
            sym_reg      <= s_axis_tdata[IN_SYM_LSB +: 16];
            cpx_reg      <= s_axis_tdata[IN_CPX_LSB +: 16];
            holes_reg    <= s_axis_tdata[IN_HOLES_LSB +: 8];
            radial_reg   <= s_axis_tdata[IN_RADIAL_LSB +: 16];
            contrast_reg <= s_axis_tdata[IN_CONTRAST_LSB +: 16];
            slot_reg     <= s_axis_tdata[IN_SLOT_LSB +: 5];
            wsel_reg     <= s_axis_tdata[IN_WSEL_LSB +: 5];
            wdata_reg    <= s_axis_tdata[IN_WDATA_LSB +: 16];
        end

        rd_idx_reg <= cmd.word;
        if (rd_pend_reg) begin
            words_reg[rd_idx_reg] <= rdata;
        end

        case (cmd.op)
            OP_BEST_INIT: begin
                best_conf_reg  <= '0;
                best_class_reg <= unknown_reg;
                best_score_reg <= -ONE_Q24;
            end
            OP_FETCH: begin
                sum_reg <= '0;
            end
            OP_SQ: begin
                sq_reg <= diff_sq[31:0];
                if (sq_valid_reg) begin
                    sum_reg <= sum_reg + 35'(sq_reg);
                end
            end
            OP_SQRT_INIT: begin
                rem_reg  <= {sum_reg, 17'b0};
                root_reg <= '0;
                bit_reg  <= 51'd1 << 50;
            end
            OP_SQRT_STEP: begin
                if (rem_reg >= trial) begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_PROF_MUL: begin
                prod_reg <= 41'($signed({1'b0, pscore}) *
                                $signed(words_reg[W_WEIGHT_PROF]));
            end
            OP_PROF_ADD: begin
                score_reg <= sat32(42'(prof_q));
                prod_reg  <= 41'(sym_reg * $signed(words_reg[W_WEIGHT_SYM]));
            end
            OP_SYM_ADD: begin
                score_reg <= sat32(42'(score_reg) + 42'(term_q));
                prod_reg  <= 41'(cpx_reg * $signed(words_reg[W_WEIGHT_CPX]));
            end
            OP_CPX_ADD: begin
                score_reg <= sat32(42'(score_reg) + 42'(term_q));
            end
            OP_HOLE: begin
                if (!w_req[15]) begin
                    if (hole_mismatch) begin
                        div_prod_reg <= abs_score * DIV_RECIP;
                        div_neg_reg  <= score_reg[31];
                        div_ten_reg  <= 1'b1;
                    end else begin
                        score_reg <= sat32(42'(score_reg) +
                            42'($signed({words_reg[W_WEIGHT_HOLE], 12'b0})));
                    end
                end
            end
            OP_DIV_FIN: begin
                score_reg <= div_neg_reg ? -$signed(div_q) : $signed(div_q);
            end
            OP_RADIAL: begin
                if (radial_reg < $signed(words_reg[W_TH_RADIAL])) begin
                    score_reg <= half(score_reg);
                end
            end
            OP_SYM_TH: begin
                if (sym_reg < $signed(words_reg[W_TH_SYM])) begin
                    score_reg <= half(score_reg);
                end
            end
            OP_CONTRAST: begin
                div_prod_reg <= abs_score * DIV_RECIP;
                div_neg_reg  <= score_reg[31];
                div_ten_reg  <= 1'b0;
            end
            OP_CONF: begin
                cur_conf_reg  <= conf_cap;
                cur_class_reg <= (conf_cap > CONF_ACCEPT) ?
                                 words_reg[W_CLASS][7:0] : unknown_reg;
            end
            OP_SELECT: begin
                if (better) begin
                    best_conf_reg  <= cur_conf_reg;
                    best_class_reg <= cur_class_reg;
                    best_score_reg <= score_reg;
                end
            end
            OP_OUT: begin
                m_data_reg <= {best_score_reg, best_conf_reg[15:0], best_class_reg};
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

>>> hw/rtl/template_score_classifier_core.sv
// Top level of the template score classifier: controller plus datapath.
// Depends on tsc_pkg, tsc_ctl, tsc_dp.
//
// Usage:
//   Input beats arrive on s_axis_*. tuser is the operation: 0 loads one 16-bit
//   record word (slot, word_select, word_data), 1 classifies the feature vector.
//   Loads give no result; each classify gives one result beat on m_axis_*.
//   Configuration (record count, floral class, unknown class) is written on the
//   cfg_* port; the user must do so while the block is idle, which it does not enforce.
// Operation:
//   A classify walks the N active records in turn: per record it streams the 17
//   words out of the table RAM, accumulates squared profile differences, runs the
//   bit-pair square root, then scales, penalizes and compares. At most one item
//   is in work at a time.
// Reset:
//   aresetn (synchronous, low) resets the controller, output valid and the
//   configuration registers (floral class to 1, the others to 0); the record
//   table keeps no reset and must be loaded before use.
// Backpressure:
//   The result sits in an output register; a new item is taken while it waits.
//   A following classify holds its result until the receiver takes the first.
module template_score_classifier_core import tsc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // profile_low[63:0], profile_high[127:64], symmetry[143:128],
    // complexity[159:144], hole_count[167:160], radial_feature[183:168],
    // contrast_feature[199:184], slot[204:200], word_select[209:205],
    // word_data[225:210], zero fill [231:226]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // label[7:0], confidence[23:8], match_score[55:24]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    tsc_ctl u_ctl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    tsc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> hw/rtl/tsc_checker.sv
// Port-level checks for the template score classifier, bound to the top level.
// Depends on tsc_pkg and template_score_classifier_core.
module tsc_checker import tsc_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // a result waiting for the receiver stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    a_conf_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[23:8] <= 16'd32768)
        else $error("confidence above one");

    // zero confidence means no record won, so the raw score is still -1.0
    a_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[23:8] == 16'd0 |->
            m_axis_tdata[55:24] == 32'hFF00_0000)
        else $error("raw score set without a winning record");

endmodule

bind template_score_classifier_core tsc_checker u_tsc_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for template_score_classifier_core.
// Loads classifier records, classifies feature beats against a fixed-point score predictor
// and checks every result beat. Depends on tsc_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
    import tsc_pkg::*;

    localparam bit OPC_LOAD     = 1'b0;
    localparam bit OPC_CLASSIFY = 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 3 + MAX_CLASSIFIERS * 70;

    typedef struct {
        bit        op;
        bit [63:0] prof_lo;
        bit [63:0] prof_hi;
        bit [15:0] sym;
        bit [15:0] cpx;
        bit [7:0]  holes;
        bit [15:0] radial;
        bit [15:0] contrast;
        bit [4:0]  slot;
        bit [4:0]  wsel;
        bit [15:0] wdata;
    } beat_t;

    typedef struct {
        bit [7:0]  label;
        bit [15:0] confidence;
        bit [31:0] match_score;
    } verdict_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // predictor state
    bit [15:0] record_words [TABLE_DEPTH];
    int        active_count;
    bit [7:0]  floral_id;
    bit [7:0]  unknown_id;

    verdict_t  pending_verdicts [$];
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_cycles = 0;

    template_score_classifier_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint sx(bit [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic verdict_t classify_features(beat_t b);
        verdict_t v;
        longint prof [PROFILE_POINTS];
        longint best_conf, best_score, score, pscore, conf, d, req;
        longint unsigned sum;
        bit [7:0] best_class, cl;
        bit better;
        int n, base;
        for (int i = 0; i < 4; i++) begin
            prof[i]     = sx(b.prof_lo[16*i +: 16]);
            prof[i + 4] = sx(b.prof_hi[16*i +: 16]);
        end
        n = (active_count > MAX_CLASSIFIERS) ? MAX_CLASSIFIERS : active_count;
        best_class = unknown_id;
        best_conf  = 0;
        best_score = -longint'(ONE_Q24);
        for (int r = 0; r < n; r++) begin
            base = r * RECORD_WORDS;
            sum = 0;
            for (int i = 0; i < PROFILE_POINTS; i++) begin
                d = prof[i] - sx(record_words[base + i]);
                sum += longint'(d * d);
            end
            pscore = longint'(ONE_Q24) - longint'(int_sqrt(sum << 17));
            if (pscore < 0) pscore = 0;
            score = sat32((pscore * sx(record_words[base + W_WEIGHT_PROF])) / 4096);
            score = sat32(score + (sx(b.sym) * sx(record_words[base + W_WEIGHT_SYM])) / 4);
            score = sat32(score + (sx(b.cpx) * sx(record_words[base + W_WEIGHT_CPX])) / 4);
            req = sx(record_words[base + W_REQ_HOLES]);
            if (req >= 0) begin
                if (longint'(b.holes) == req)
                    score = sat32(score + sx(record_words[base + W_WEIGHT_HOLE]) * 4096);
                else
                    score = score / 10;
            end
            if (sx(b.radial) < sx(record_words[base + W_TH_RADIAL])) score = score / 2;
            if (sx(b.sym) < sx(record_words[base + W_TH_SYM])) score = score / 2;
            if (sx(record_words[base + W_TH_CONTRAST]) > 0 &&
                sx(b.contrast) > sx(record_words[base + W_TH_CONTRAST]))
                score = score / 5;
            conf = score / 2048;
            if (conf > 32768) conf = 32768;
            cl = (conf > 16384) ? record_words[base + W_CLASS][7:0] : unknown_id;
            better = 1'b0;
            if (conf > best_conf) begin
                better = 1'b1;
            end else if (conf == best_conf && best_conf > 0) begin
                if (best_class == floral_id && cl != floral_id) better = 1'b1;
                else if (cl != floral_id && cl > best_class) better = 1'b1;
            end
            if (better) begin
                best_class = cl;
                best_conf  = conf;
                best_score = score;
            end
        end
        v.label       = best_class;
        v.confidence  = best_conf[15:0];
        v.match_score = best_score[31:0];
        return v;
    endfunction

    // send one beat; the prediction is taken at the accepting edge
    task automatic send_beat(beat_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.op;
        s_tdata  <= {6'b0, b.wdata, b.wsel, b.slot, b.contrast, b.radial, b.holes,
                     b.cpx, b.sym, b.prof_hi, b.prof_lo};
        do @(posedge aclk); while (!s_tready);
        if (b.op == OPC_CLASSIFY)
            pending_verdicts.push_back(classify_features(b));
        else if (b.wsel < RECORD_WORDS)
            record_words[int'(b.slot) * RECORD_WORDS + b.wsel] = b.wdata;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (pending_verdicts.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, bit [7:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CLASSIFIER_COUNT: active_count = val[5:0];
            REG_FLORAL_CLASS:     floral_id = val;
            REG_UNKNOWN_CLASS:    unknown_id = val;
            default: ;
        endcase
    endtask

    task automatic load_word(int slot, int wsel, bit [15:0] data);
        beat_t b;
        b = '{default: '0};
        b.op    = OPC_LOAD;
        b.slot  = slot[4:0];
        b.wsel  = wsel[4:0];
        b.wdata = data;
        b.prof_lo = {$urandom, $urandom};
        send_beat(b);
    endtask

    function automatic bit [15:0] random_word(int wsel);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 16'($urandom);
        if (wsel < PROFILE_POINTS) return 16'($urandom_range(32767) - 16384);
        case (wsel)
            W_WEIGHT_PROF: return 16'($urandom_range(32767, 2048));
            W_WEIGHT_SYM, W_WEIGHT_CPX, W_WEIGHT_HOLE:
                return 16'($urandom_range(4096) - 2048);
            W_TH_RADIAL, W_TH_SYM:
                return (sel < 7) ? 16'hC000 : 16'($urandom_range(16384) - 8192);
            W_TH_CONTRAST: return (sel < 5) ? 16'h0000 : 16'($urandom_range(16383));
            W_REQ_HOLES:   return (sel < 4) ? 16'hFFFF : 16'($urandom_range(3));
            default:       return (sel < 3) ? {8'h0, floral_id} : 16'($urandom_range(255));
        endcase
    endfunction

    task automatic load_record(int slot);
        for (int w = 0; w < RECORD_WORDS; w++) load_word(slot, w, random_word(w));
    endtask

    // feature vector close to record r, or fully random noise
    function automatic beat_t make_classify(int r, bit close);
        beat_t b;
        int base, noise;
        b = '{default: '0};
        b.op       = OPC_CLASSIFY;
        b.prof_lo  = {$urandom, $urandom};
        b.prof_hi  = {$urandom, $urandom};
        b.sym      = 16'($urandom);
        b.cpx      = 16'($urandom);
        b.holes    = 8'($urandom);
        b.radial   = 16'($urandom);
        b.contrast = 16'($urandom);
        b.slot     = 5'($urandom);
        b.wsel     = 5'($urandom);
        b.wdata    = 16'($urandom);
        if (close) begin
            base  = r * RECORD_WORDS;
            noise = $urandom_range(1200);
            for (int i = 0; i < 4; i++) begin
                b.prof_lo[16*i +: 16] = record_words[base + i] +
                                        16'($urandom_range(noise) - noise / 2);
                b.prof_hi[16*i +: 16] = record_words[base + 4 + i] +
                                        16'($urandom_range(noise) - noise / 2);
            end
            b.sym      = 16'($urandom_range(16384));
            b.cpx      = 16'($urandom_range(16384) - 8192);
            b.holes    = ($urandom_range(3) != 0) ? record_words[base + W_REQ_HOLES][7:0]
                                                  : 8'($urandom_range(4));
            b.radial   = 16'($urandom_range(16384) - 4096);
            b.contrast = 16'($urandom_range(8192));
        end
        return b;
    endfunction

    // result beat checker
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no classify outstanding: %h", m_tdata);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[7:0] !== want.label) begin
                    $error("label expected %0d got %0d", want.label, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[23:8] !== want.confidence) begin
                    $error("confidence expected %0d got %0d", want.confidence,
                           m_tdata[23:8]);
                    error_count++;
                end
                if (m_tdata[55:24] !== want.match_score) begin
                    $error("match_score expected %0d got %0d", $signed(want.match_score),
                           $signed(m_tdata[55:24]));
                    error_count++;
                end
            end
        end
    end

    // result-side ready, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic test_empty_table();
        send_beat(make_classify(0, 1'b0));
        write_reg(REG_UNKNOWN_CLASS, 8'hFF);
        write_reg(REG_UNUSED, 8'h21);
        send_beat(make_classify(0, 1'b0));
    endtask

    task automatic test_directed();
        beat_t b;
        bit [15:0] rec [RECORD_WORDS];
        int cls [3];
        cls = '{7, 1, 9};
        for (int i = 0; i < PROFILE_POINTS; i++) rec[i] = 16'h2000;
        rec[W_WEIGHT_PROF] = 16'h4000;
        rec[W_WEIGHT_SYM]  = 16'h0400;
        rec[W_WEIGHT_CPX]  = 16'h0400;
        rec[W_WEIGHT_HOLE] = 16'h0200;
        rec[W_TH_RADIAL]   = 16'h0000;
        rec[W_TH_SYM]      = 16'hC000;
        rec[W_TH_CONTRAST] = 16'h1000;
        rec[W_REQ_HOLES]   = 16'd2;
        for (int r = 0; r < 3; r++) begin
            rec[W_CLASS] = 16'(cls[r]);
            for (int w = 0; w < RECORD_WORDS; w++) load_word(r, w, rec[w]);
        end
        // out-of-range word selects are dropped
        load_word(0, RECORD_WORDS, 16'hFFFF);
        load_word(1, 31, 16'h0000);
        write_reg(REG_CLASSIFIER_COUNT, 8'd3);
        write_reg(REG_UNKNOWN_CLASS, 8'd0);

        b = make_classify(0, 1'b0);
        b.prof_lo = {4{16'h2000}};
        b.prof_hi = {4{16'h2000}};
        b.sym = 16'h0000; b.cpx = 16'h0000; b.holes = 8'd2;
        b.radial = 16'h0100; b.contrast = 16'h0000;
        send_beat(b);                       // exact match, ties among all three
        b.holes = 8'd3;       send_beat(b); // hole mismatch
        b.holes = 8'd2; b.radial = 16'hFFFF; send_beat(b); // radial miss
        b.radial = 16'h0100; b.sym = 16'h8000; send_beat(b); // symmetry miss
        b.sym = 16'h0000; b.contrast = 16'h7FFF; send_beat(b); // contrast miss
        b.prof_lo = '1; b.prof_hi = '1; b.holes = 8'hFF; send_beat(b);
        b.prof_lo = {4{16'h7FFF}}; b.prof_hi = {4{16'h8000}};
        b.sym = 16'h7FFF; b.cpx = 16'h7FFF; b.radial = 16'h7FFF; send_beat(b);
        b.prof_lo = {4{16'h8000}}; b.sym = 16'h8000; b.cpx = 16'h8000;
        b.radial = 16'h8000; b.contrast = 16'h8000; b.holes = 8'h00; send_beat(b);
        write_reg(REG_FLORAL_CLASS, 8'd7);
        b = make_classify(0, 1'b1); b.holes = 8'd2; send_beat(b);
        write_reg(REG_FLORAL_CLASS, 8'd255);
        write_reg(REG_FLORAL_CLASS, 8'd0);
        send_beat(b);
        write_reg(REG_FLORAL_CLASS, 8'd1);
    endtask

    task automatic test_random(int beats, int idle, int stall);
        int n, sel;
        send_idle_pct = idle;
        stall_pct     = stall;
        write_reg(REG_UNKNOWN_CLASS, 8'($urandom));
        write_reg(REG_CLASSIFIER_COUNT, 8'($urandom_range(6, 1)));
        n = active_count;
        for (int k = 0; k < beats; k++) begin
            sel = $urandom_range(99);
            if (sel < 30)
                load_word($urandom_range(n - 1), $urandom_range(16),
                          random_word($urandom_range(16)));
            else if (sel < 33)
                load_word($urandom_range(31), $urandom_range(31, RECORD_WORDS),
                          16'($urandom));
            else if (sel < 85)
                send_beat(make_classify($urandom_range(n - 1), 1'b1));
            else
                send_beat(make_classify(0, 1'b0));
        end
    endtask

    task automatic test_full_table();
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int r = 0; r < MAX_CLASSIFIERS; r++) load_record(r);
        write_reg(REG_CLASSIFIER_COUNT, 8'd32);
        for (int k = 0; k < 4; k++)
            send_beat(make_classify($urandom_range(31), 1'b1));
        write_reg(REG_CLASSIFIER_COUNT, 8'd63);
        for (int k = 0; k < 2; k++)
            send_beat(make_classify($urandom_range(31), 1'b1));
        write_reg(REG_CLASSIFIER_COUNT, 8'd4);
    endtask

    task automatic test_backpressure();
        // hold the result side so the output register and the core both fill
        hold_cycles = 3000;
        for (int k = 0; k < 8; k++) send_beat(make_classify($urandom_range(3), 1'b1));
        drain_results();
        for (int k = 0; k < 4; k++) send_beat(make_classify($urandom_range(3), 1'b1));
    endtask

    initial begin
        active_count = 0;
        floral_id    = 8'd1;
        unknown_id   = 8'd0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_table();
        test_directed();
        for (int r = 3; r < 6; r++) load_record(r);
        test_random(100, 8, 70);
        test_random(100, 70, 8);
        test_random(100, 0, 0);
        test_full_table();
        test_backpressure();

        drain_results();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_ram.sv
hw/rtl/tsc_ctl.sv
hw/rtl/tsc_dp.sv
hw/rtl/template_score_classifier_core.sv
hw/rtl/tsc_checker.sv
tb/testbench.sv
